FILE: rtl/rotation_matrix_to_euler_unit_assert.svh
// Assertion macros for the rotation-to-Euler unit.
`ifndef ROTATION_MATRIX_TO_EULER_UNIT_ASSERT_SVH
`define ROTATION_MATRIX_TO_EULER_UNIT_ASSERT_SVH

// ante |-> cons, same cycle
`define RMTE_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("rmte check failed");

// ante |=> cons, next cycle
`define RMTE_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("rmte check failed");

`endif

FILE: rtl/rmte_pkg.sv
`default_nettype none
package rmte_pkg;
	typedef logic signed [35:0] acc_t;
	typedef logic signed [15:0] angle_t;

	localparam int TAB_LEN = 24;
	localparam acc_t PI_Q30 = 36'sd3373259426;
	localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
	localparam acc_t ANGLE_LIMIT = 36'sd25736;
	localparam acc_t HALF_LSB = 36'sd65536;

	typedef struct packed {
		acc_t a00;
		acc_t a10;
		acc_t a20n;
		acc_t a21;
		acc_t a22;
		acc_t a11;
		acc_t a12n;
	} vec_t;

	function automatic acc_t atan_q30(input logic [4:0] i);
		acc_t r;
		case (i)
			5'd0: r = 36'sd843314856;
			5'd1: r = 36'sd497837829;
			5'd2: r = 36'sd263043836;
			5'd3: r = 36'sd133525158;
			5'd4: r = 36'sd67021686;
			5'd5: r = 36'sd33543515;
			5'd6: r = 36'sd16775850;
			5'd7: r = 36'sd8388437;
			5'd8: r = 36'sd4194282;
			5'd9: r = 36'sd2097149;
			5'd10: r = 36'sd1048575;
			5'd11: r = 36'sd524287;
			5'd12: r = 36'sd262143;
			5'd13: r = 36'sd131071;
			5'd14: r = 36'sd65535;
			5'd15: r = 36'sd32767;
			5'd16: r = 36'sd16383;
			5'd17: r = 36'sd8191;
			5'd18: r = 36'sd4095;
			5'd19: r = 36'sd2047;
			5'd20: r = 36'sd1023;
			5'd21: r = 36'sd511;
			5'd22: r = 36'sd255;
			5'd23: r = 36'sd127;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Q.30 radians to Q3.13 with rounding and clamp
	function automatic angle_t angle_out(input acc_t z);
		acc_t s;
		s = (z + HALF_LSB) >>> 17;
		if (s > ANGLE_LIMIT) begin
			s = ANGLE_LIMIT;
		end else if (s < -ANGLE_LIMIT) begin
			s = -ANGLE_LIMIT;
		end
		return 16'(s);
	endfunction
endpackage
`default_nettype wire

FILE: rtl/rmte_front.sv
`default_nettype none
module rmte_front #(
	parameter int ELEMENT_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic signed [ELEMENT_BITS-1:0] r00,
	input  wire logic signed [ELEMENT_BITS-1:0] r10,
	input  wire logic signed [ELEMENT_BITS-1:0] r20,
	input  wire logic signed [ELEMENT_BITS-1:0] r21,
	input  wire logic signed [ELEMENT_BITS-1:0] r22,
	input  wire logic signed [ELEMENT_BITS-1:0] r11,
	input  wire logic signed [ELEMENT_BITS-1:0] r12,
	output logic                                head_valid,
	input  wire logic                           head_take,
	output rmte_pkg::vec_t                      head
);
	localparam int EB = ELEMENT_BITS;
	localparam int DEPTH = 4;
	localparam int SHL = (EB <= 30) ? 30 - EB : 0;
	localparam int SHR = (EB > 30) ? EB - 30 : 0;
	localparam logic signed [EB-1:0] EMIN = {1'b1, {(EB-1){1'b0}}};
	localparam logic signed [EB-1:0] EMAX = {1'b0, {(EB-1){1'b1}}};

	typedef logic [7*EB-1:0] raw_t;

	raw_t       mem_q [DEPTH];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       wr_en, rd_en;
	logic signed [EB-1:0] h00, h10, h20, h21, h22, h11, h12;

	function automatic rmte_pkg::acc_t to_q28(input logic signed [EB-1:0] e);
		rmte_pkg::acc_t t;
		t = 36'(e);
		t = (t <<< SHL) >>> SHR;
		return t;
	endfunction

	function automatic logic signed [EB-1:0] neg_sat(input logic signed [EB-1:0] e);
		return (e == EMIN) ? EMAX : -e;
	endfunction

	assign full = (cnt_q == 3'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign wr_en = push && !full;
	assign rd_en = head_take && head_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= {r00, r10, r20, r21, r22, r11, r12};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wr_q <= wr_q + 2'd1;
			if (rd_en) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(wr_en) - 3'(rd_en);
		end
	end

	assign {h00, h10, h20, h21, h22, h11, h12} = mem_q[rd_q];

	always_comb begin
		head.a00 = to_q28(h00);
		head.a10 = to_q28(h10);
		head.a20n = to_q28(neg_sat(h20));
		head.a21 = to_q28(h21);
		head.a22 = to_q28(h22);
		head.a11 = to_q28(h11);
		head.a12n = to_q28(neg_sat(h12));
	end
endmodule
`default_nettype wire

FILE: rtl/rmte_cordic.sv
`default_nettype none
module rmte_cordic #(
	parameter int STEPS = 14
) (
	input  wire logic           clk,
	input  wire logic           adv,
	input  rmte_pkg::acc_t      x_in,
	input  rmte_pkg::acc_t      y_in,
	output rmte_pkg::acc_t      z_out,
	output rmte_pkg::acc_t      mag_out
);
	rmte_pkg::acc_t x_s [0:STEPS];
	rmte_pkg::acc_t y_s [0:STEPS];
	rmte_pkg::acc_t z_s [0:STEPS];
	logic           zf_s [0:STEPS];

	// left half plane: turn by pi first
	always_ff @(posedge clk) begin
		if (adv) begin
			zf_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				z_s[0] <= (y_in >= 0) ? rmte_pkg::PI_Q30 : -rmte_pkg::PI_Q30;
				x_s[0] <= -x_in;
				y_s[0] <= -y_in;
			end else begin
				z_s[0] <= '0;
				x_s[0] <= x_in;
				y_s[0] <= y_in;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_it
		always_ff @(posedge clk) begin
			if (adv) begin
				zf_s[i+1] <= zf_s[i];
				if (y_s[i] < 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - rmte_pkg::atan_q30(5'(i));
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + rmte_pkg::atan_q30(5'(i));
				end
			end
		end
	end

	assign z_out = zf_s[STEPS] ? '0 : z_s[STEPS];
	assign mag_out = zf_s[STEPS] ? '0 : x_s[STEPS];
endmodule
`default_nettype wire

FILE: rtl/rmte_back.sv
`default_nettype none
module rmte_back #(
	parameter int STEPS = 14
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  rmte_pkg::vec_t       in_item,
	output logic                 in_take,
	input  wire logic [14:0]     threshold,
	output logic                 out_valid,
	input  wire logic            out_take,
	output rmte_pkg::angle_t     ax_out,
	output rmte_pkg::angle_t     ay_out,
	output rmte_pkg::angle_t     az_out,
	output logic                 sing_out
);
	localparam int LAT = STEPS + 1;

	logic adv;
	logic ov_q;

	rmte_pkg::acc_t z_z, m_z, z_xn, m_xn, z_xs, m_xs, z_y, m_y;

	logic           va_q [LAT];
	rmte_pkg::acc_t n20_q [LAT];

	logic [61:0]    prod_s1;
	rmte_pkg::acc_t az_s1, axn_s1, axs_s1, n20_s1;
	logic           v_s1;

	logic [61:0]    rnd;
	logic           sing;
	rmte_pkg::acc_t sy_s2, ax_s2, az_s2;
	logic           v_s2, sing_s2;
	rmte_pkg::acc_t n20_s2_q;

	logic           vb_q [LAT];
	rmte_pkg::acc_t axb_q [LAT];
	rmte_pkg::acc_t azb_q [LAT];
	logic           sb_q [LAT];

	assign adv = !ov_q || out_take;
	assign in_take = adv && in_valid;
	assign out_valid = ov_q;

	rmte_cordic #(.STEPS(STEPS)) u_cz (
		.clk(clk), .adv(adv), .x_in(in_item.a00), .y_in(in_item.a10),
		.z_out(z_z), .mag_out(m_z));
	rmte_cordic #(.STEPS(STEPS)) u_cxn (
		.clk(clk), .adv(adv), .x_in(in_item.a22), .y_in(in_item.a21),
		.z_out(z_xn), .mag_out(m_xn));
	rmte_cordic #(.STEPS(STEPS)) u_cxs (
		.clk(clk), .adv(adv), .x_in(in_item.a11), .y_in(in_item.a12n),
		.z_out(z_xs), .mag_out(m_xs));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) va_q[k] <= 1'b0;
		end else if (adv) begin
			va_q[0] <= in_valid;
			for (int k = 1; k < LAT; k++) va_q[k] <= va_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n20_q[0] <= in_item.a20n;
			for (int k = 1; k < LAT; k++) n20_q[k] <= n20_q[k-1];
		end
	end

	// inverse gain scaling of the magnitude
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= m_z[31:0] * rmte_pkg::INV_GAIN_Q30;
			az_s1 <= z_z;
			axn_s1 <= z_xn;
			axs_s1 <= z_xs;
			n20_s1 <= n20_q[LAT-1];
		end
	end

	assign rnd = prod_s1 + 62'(1 << 29);
	assign sing = {4'b0, rnd[61:30]} < {7'b0, threshold, 14'b0};

	always_ff @(posedge clk) begin
		if (adv) begin
			sy_s2 <= {4'b0, rnd[61:30]};
			sing_s2 <= sing;
			ax_s2 <= sing ? axs_s1 : axn_s1;
			az_s2 <= az_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= va_q[LAT-1];
			v_s2 <= v_s1;
		end
	end

	rmte_cordic #(.STEPS(STEPS)) u_cy (
		.clk(clk), .adv(adv), .x_in(sy_s2), .y_in(n20_s2_q),
		.z_out(z_y), .mag_out(m_y));

	always_ff @(posedge clk) begin
		if (adv) n20_s2_q <= n20_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) vb_q[k] <= 1'b0;
		end else if (adv) begin
			vb_q[0] <= v_s2;
			for (int k = 1; k < LAT; k++) vb_q[k] <= vb_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			axb_q[0] <= ax_s2;
			azb_q[0] <= az_s2;
			sb_q[0] <= sing_s2;
			for (int k = 1; k < LAT; k++) begin
				axb_q[k] <= axb_q[k-1];
				azb_q[k] <= azb_q[k-1];
				sb_q[k] <= sb_q[k-1];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (adv) begin
			ov_q <= vb_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_out <= rmte_pkg::angle_out(axb_q[LAT-1]);
			ay_out <= rmte_pkg::angle_out(z_y);
			az_out <= sb_q[LAT-1] ? '0 : rmte_pkg::angle_out(azb_q[LAT-1]);
			sing_out <= sb_q[LAT-1];
		end
	end

	logic unused_mag;
	assign unused_mag = ^{m_xn, m_xs, m_y};
endmodule
`default_nettype wire

FILE: rtl/rotation_matrix_to_euler_unit.sv
// channel   ports                                  handshake
// input     r00 r10 r20 r21 r22 r11 r12            push / full
// result    angle_x angle_y angle_z is_singular    empty / pop
// config    cfg_data (singular_threshold)          cfg_valid / cfg_ready
//
// One item per cycle sustained while results are popped. The two CORDIC
// pipelines on the path from push to !empty are chained (magnitude first,
// then the Y angle).
// Reset clears queue pointers and pipeline valids; threshold resets to 1.
// While a result waits and is not popped the whole back pipeline holds; the
// four-entry input queue keeps taking items until full.
`default_nettype none
module rotation_matrix_to_euler_unit #(
	parameter int CORDIC_STEPS = 14,
	parameter int ELEMENT_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic signed [ELEMENT_BITS-1:0] r00,
	input  wire logic signed [ELEMENT_BITS-1:0] r10,
	input  wire logic signed [ELEMENT_BITS-1:0] r20,
	input  wire logic signed [ELEMENT_BITS-1:0] r21,
	input  wire logic signed [ELEMENT_BITS-1:0] r22,
	input  wire logic signed [ELEMENT_BITS-1:0] r11,
	input  wire logic signed [ELEMENT_BITS-1:0] r12,
	output logic                                empty,
	input  wire logic                           pop,
	output logic signed [15:0]                  angle_x,
	output logic signed [15:0]                  angle_y,
	output logic signed [15:0]                  angle_z,
	output logic                                is_singular,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [14:0]                    cfg_data
);
	localparam int STEPS = (CORDIC_STEPS < rmte_pkg::TAB_LEN) ?
		CORDIC_STEPS : rmte_pkg::TAB_LEN;

	logic [14:0]    threshold_q;
	logic           head_valid, head_take, out_valid;
	rmte_pkg::vec_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= 15'd1;
		end else if (cfg_valid && cfg_ready) begin
			threshold_q <= cfg_data;
		end
	end

	rmte_front #(.ELEMENT_BITS(ELEMENT_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.r00(r00), .r10(r10), .r20(r20), .r21(r21), .r22(r22),
		.r11(r11), .r12(r12),
		.head_valid(head_valid), .head_take(head_take), .head(head));

	rmte_back #(.STEPS(STEPS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(head_valid), .in_item(head), .in_take(head_take),
		.threshold(threshold_q),
		.out_valid(out_valid), .out_take(pop),
		.ax_out(angle_x), .ay_out(angle_y), .az_out(angle_z),
		.sing_out(is_singular));

	assign empty = !out_valid;
endmodule
`default_nettype wire

FILE: rtl/rmte_checker.sv
`default_nettype none
`include "rotation_matrix_to_euler_unit_assert.svh"
module rmte_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               empty,
	input wire logic               pop,
	input wire logic signed [15:0] angle_x,
	input wire logic signed [15:0] angle_y,
	input wire logic signed [15:0] angle_z,
	input wire logic               is_singular
);
	`RMTE_ASSERT_NOW(a_sing_z, clk, arst_n, !empty && is_singular, angle_z == 16'sd0)
	`RMTE_ASSERT_NOW(a_x_rng, clk, arst_n, !empty, angle_x <= 16'sd25736 && angle_x >= -16'sd25736)
	`RMTE_ASSERT_NOW(a_y_rng, clk, arst_n, !empty, angle_y <= 16'sd25736 && angle_y >= -16'sd25736)
	`RMTE_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(angle_y))
endmodule

bind rotation_matrix_to_euler_unit rmte_checker u_rmte_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
	.is_singular(is_singular));
`default_nettype wire

FILE: test/rotation_matrix_to_euler_unit_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module rotation_matrix_to_euler_unit_tb;
	localparam int STEPS = 14;
	localparam longint PI_VAL = 64'sd3373259426;
	localparam longint INV_GAIN = 64'sd652032874;
	localparam int LATENCY = 2 * (STEPS + 1) + 3;

	typedef struct packed {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic               sing;
	} euler_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty, cfg_ready, is_singular;
	logic signed [15:0] r00 = '0, r10 = '0, r20 = '0, r21 = '0, r22 = '0, r11 = '0, r12 = '0;
	logic signed [15:0] angle_x, angle_y, angle_z;
	logic cfg_valid = 1'b0;
	logic [14:0] cfg_data = '0;

	logic [14:0] threshold = 15'd1;
	euler_t expected_angles[$];
	int failures = 0;
	int push_idle = 0;
	int pop_idle = 0;

	rotation_matrix_to_euler_unit dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.r00(r00), .r10(r10), .r20(r20), .r21(r21), .r22(r22), .r11(r11), .r12(r12),
		.empty(empty), .pop(pop),
		.angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z), .is_singular(is_singular),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint neg_sat(longint e);
		if (e == -32768) begin
			return 32767;
		end
		return -e;
	endfunction

	function automatic longint vector_angle(longint x, longint y, output longint mag);
		longint z, dx, dy;
		longint tab[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
			33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
			131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
		z = 0;
		if (x == 0 && y == 0) begin
			mag = 0;
			return 0;
		end
		if (x < 0) begin
			z = (y >= 0) ? PI_VAL : -PI_VAL;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = fshift(y, i);
			dy = fshift(x, i);
			if (y < 0) begin
				x -= dx;
				y += dy;
				z -= tab[i];
			end else begin
				x += dx;
				y -= dy;
				z += tab[i];
			end
		end
		mag = (x * INV_GAIN + (64'sd1 <<< 29)) >>> 30;
		return z;
	endfunction

	function automatic logic signed [15:0] to_q313(longint z);
		longint a;
		a = fshift(z + 65536, 17);
		if (a > 25736) a = 25736;
		if (a < -25736) a = -25736;
		return a[15:0];
	endfunction

	function automatic euler_t predict_euler(longint e00, e10, e20, e21, e22, e11, e12);
		longint sy, dummy, zx, zy, zz;
		euler_t res;
		zz = vector_angle(e00 <<< 14, e10 <<< 14, sy);
		res.sing = sy < (longint'(threshold) <<< 14);
		if (res.sing) begin
			zx = vector_angle(e11 <<< 14, neg_sat(e12) <<< 14, dummy);
		end else begin
			zx = vector_angle(e22 <<< 14, e21 <<< 14, dummy);
		end
		zy = vector_angle(sy, neg_sat(e20) <<< 14, dummy);
		res.ax = to_q313(zx);
		res.ay = to_q313(zy);
		res.az = res.sing ? 16'sd0 : to_q313(zz);
		return res;
	endfunction

	task automatic send_matrix(logic signed [15:0] a00, a10, a20, a21, a22, a11, a12);
		while (push_idle > 0 && $urandom_range(99) < push_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		r00 <= a00; r10 <= a10; r20 <= a20; r21 <= a21;
		r22 <= a22; r11 <= a11; r12 <= a12;
		@(posedge clk);
		while (full) @(posedge clk);
		expected_angles.push_back(predict_euler(a00, a10, a20, a21, a22, a11, a12));
		@(negedge clk);
	endtask

	task automatic drain;
		push <= 1'b0;
		while (expected_angles.size() > 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_threshold(logic [14:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		threshold = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [15:0] rnd_elem();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sd0;
			3: return 16'($signed($urandom_range(64)) - 32);
			4, 5, 6: return 16'($signed($urandom_range(32768)) - 16384);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_matrix();
		real th, ps, c, s;
		logic signed [15:0] a, b;
		if ($urandom_range(3) == 0) begin
			send_matrix(rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(),
				rnd_elem(), rnd_elem());
		end else begin
			// consistent rotation-like first column, incl. near gimbal lock
			th = $urandom_range(6283) / 1000.0;
			ps = ($urandom_range(4) == 0) ? 1.5707 : $urandom_range(3141) / 1000.0 - 1.57;
			c = $cos(ps);
			s = $sin(ps);
			a = 16'($rtoi(16384.0 * c * $cos(th)));
			b = 16'($rtoi(16384.0 * c * $sin(th)));
			send_matrix(a, b, 16'($rtoi(-16384.0 * s)), rnd_elem(), rnd_elem(),
				rnd_elem(), rnd_elem());
		end
	endtask

	task automatic test_directed;
		send_matrix(16'sd16384, 0, 0, 0, 16'sd16384, 16'sd16384, 0);
		send_matrix(0, 0, 0, 0, 0, 0, 0);
		send_matrix(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_matrix(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_matrix(-16'sd16384, 0, 0, 0, -16'sd16384, -16'sd16384, 0);
		send_matrix(-16'sd16384, -16'sd1, 0, -16'sd1, -16'sd16384, 0, 16'sd5);
		send_matrix(-16'sd16384, 0, 16'sd100, 0, -16'sd1, 16'sd3, 16'sh8000);
		send_matrix(0, 0, 16'sd16384, 16'sd100, 16'sd200, 16'sd300, 16'sd400);
		send_matrix(0, 0, -16'sd16384, 16'sd100, 16'sd200, -16'sd300, -16'sd400);
		send_matrix(0, 16'sd1, 16'sh8000, 16'sd1, 0, 0, 0);
		send_matrix(16'sd11585, 16'sd11585, 0, 16'sd11585, -16'sd11585, 0, 0);
		send_matrix(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555);
		send_matrix(16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
	endtask

	task automatic test_thresholds;
		logic [14:0] set[5] = '{15'd0, 15'd16384, 15'd8192, 15'd300, 15'd1};
		for (int k = 0; k < 5; k++) begin
			write_threshold(set[k]);
			for (int n = 0; n < 12; n++) random_matrix();
		end
	endtask

	task automatic test_random(int count);
		for (int n = 0; n < count; n++) begin
			if (n == count / 2) write_threshold(15'($urandom_range(16384)));
			random_matrix();
		end
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_thresholds();
		push_idle = 22; pop_idle = 51;
		test_random(200);
		push_idle = 51; pop_idle = 22;
		test_random(200);
		push_idle = 0; pop_idle = 0;
		test_random(240);
		drain();
		if (failures == 0 && expected_angles.size() == 0) begin
			$display("rotation_matrix_to_euler_unit_tb OK");
		end else begin
			$display("rotation_matrix_to_euler_unit_tb NOT OK");
		end
		$finish;
	end

	always @(negedge clk) begin
		pop <= !(pop_idle > 0 && $urandom_range(99) < pop_idle);
	end

	always @(posedge clk) begin
		euler_t want;
		if (arst_n && pop && !empty) begin
			if (expected_angles.size() == 0) begin
				$error("unexpected item");
				failures++;
			end else begin
				want = expected_angles.pop_front();
				if (angle_x !== want.ax) begin
					$error("angle_x exp %0d got %0d", want.ax, angle_x);
					failures++;
				end
				if (angle_y !== want.ay) begin
					$error("angle_y exp %0d got %0d", want.ay, angle_y);
					failures++;
				end
				if (angle_z !== want.az) begin
					$error("angle_z exp %0d got %0d", want.az, angle_z);
					failures++;
				end
				if (is_singular !== want.sing) begin
					$error("is_singular exp %0d got %0d", want.sing, is_singular);
					failures++;
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("rotation_matrix_to_euler_unit_tb NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
